[rtl/mbcs_pkg.sv]
// ----------------------------------------------------------------------------
// mbcs_pkg
// Shared types and codes for the multibyte charset character counter.
// ----------------------------------------------------------------------------
package mbcs_pkg;

  localparam int MAX_STATES    = 128;
  localparam int MAX_SEQ_BYTES = 255;
  localparam int STATE_W       = $clog2(MAX_STATES);
  localparam int TBL_ADDR_W    = STATE_W + 8;

  localparam int S_TDATA_W = 40;
  localparam int M_TDATA_W = 16;
  localparam int OQ_DEPTH  = 3;

  localparam logic KIND_BYTE  = 1'b0;
  localparam logic KIND_TABLE = 1'b1;

  localparam logic [3:0] ACT_ILLEGAL     = 4'd0;
  localparam logic [3:0] ACT_CHANGE_ONLY = 4'd1;
  localparam logic [3:0] ACT_UNASSIGNED  = 4'd2;
  localparam logic [3:0] ACT_VALID_LO    = 4'd3;
  localparam logic [3:0] ACT_VALID_HI    = 4'd8;

  localparam logic [2:0] ERR_NONE        = 3'd0;
  localparam logic [2:0] ERR_NO_STATES   = 3'd1;
  localparam logic [2:0] ERR_ILLEGAL     = 3'd2;
  localparam logic [2:0] ERR_CHANGE_ONLY = 3'd3;
  localparam logic [2:0] ERR_UNASSIGNED  = 3'd4;
  localparam logic [2:0] ERR_RESERVED    = 3'd5;
  localparam logic [2:0] ERR_TOO_SHORT   = 3'd6;
  localparam logic [2:0] ERR_NOT_DBCS    = 3'd7;

  localparam logic [STATE_W-1:0] START_STATE_SBCS = STATE_W'(0);
  localparam logic [STATE_W-1:0] START_STATE_DBCS = STATE_W'(1);
  localparam logic [7:0]         DBCS_SEQ_LEN     = 8'd2;

  localparam logic REG_IDX_STATE_COUNT = 1'b0;
  localparam logic REG_IDX_SISO_MODE   = 1'b1;

  typedef struct packed {
    logic               fin;
    logic [STATE_W-1:0] nxt;
    logic [3:0]         act;
  } entry_t;

  typedef struct packed {
    logic               kind;
    logic               last;
    logic [7:0]         byte_value;
    logic [7:0]         seq_length;
    logic [STATE_W-1:0] row_index;
    logic               entry_is_final;
    logic [STATE_W-1:0] entry_next_state;
    logic [3:0]         entry_action;
  } item_t;

  typedef struct packed {
    logic [2:0] error_code;
    logic [7:0] char_count;
  } result_t;

endpackage

[rtl/mbcs_byte_sequence_char_counter_unit.sv]
// ----------------------------------------------------------------------------
// mbcs_byte_sequence_char_counter_unit
// Counts complete characters of byte sequences against a loaded charset state
// table, reporting the count or the first error on the last byte.
// ----------------------------------------------------------------------------
// Usage: the input stream carries table-write words (tuser = 1) and sequence
// bytes (tuser = 0, tlast on the final byte of a sequence). Each sequence
// byte reads one entry of a 128 x 256 table held in a synchronous RAM; the
// next read address is formed from the entry returned for the previous
// byte, so one word is accepted every cycle unless input is held off.
// A result is registered in the evaluation stage and then in the result
// queue before it is offered on the output stream. Table writes and
// non-final bytes give no result. A three-deep result queue parts the
// two sides; input is held off only while the queue and the byte under
// evaluation could fill it, so a stalled receiver blocks input after at
// most three results wait.
// Reset clears the sequence state and the configuration registers; the
// table is not cleared and must be written before it is used. The user must
// write configuration over the register port while idle; it is not enforced.
// ----------------------------------------------------------------------------
module mbcs_byte_sequence_char_counter_unit (
  input  logic        clk,
  input  logic        rst,
  // Input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  // byte_value[7:0], seq_length[15:8], row_index[22:16], entry_is_final[23],
  // entry_next_state[30:24], entry_action[34:31], zero[39:35]
  input  logic [mbcs_pkg::S_TDATA_W-1:0] s_tdata,
  input  logic        s_tlast,
  // kind[0]
  input  logic        s_tuser,
  // Output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  // char_count[7:0], error_code[10:8], zero[15:11]
  output logic [mbcs_pkg::M_TDATA_W-1:0] m_tdata,
  // Register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import mbcs_pkg::*;

  logic       cfg_we;
  logic [7:0] state_count;
  logic       siso_mode;

  item_t      item;
  logic       s_accept;
  logic       res_valid;
  result_t    res;
  result_t    q_head;
  logic [1:0] q_level;
  logic       m_pop;

  // Register port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state_count <= 8'd0;
      siso_mode   <= 1'b0;
    end else if (cfg_we) begin
      unique case (paddr[2])
        REG_IDX_STATE_COUNT: state_count <= pwdata[7:0];
        REG_IDX_SISO_MODE:   siso_mode   <= pwdata[0];
        default:             state_count <= state_count;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      REG_IDX_STATE_COUNT: prdata = {24'd0, state_count};
      REG_IDX_SISO_MODE:   prdata = {31'd0, siso_mode};
      default:             prdata = '0;
    endcase
  end

  // Input word unpacking
  assign item.kind             = s_tuser;
  assign item.last             = s_tlast;
  assign item.byte_value       = s_tdata[7:0];
  assign item.seq_length       = s_tdata[15:8];
  assign item.row_index        = s_tdata[22:16];
  assign item.entry_is_final   = s_tdata[23];
  assign item.entry_next_state = s_tdata[30:24];
  assign item.entry_action     = s_tdata[34:31];

  // Room is kept for the result of the byte under evaluation and for one
  // more from the word about to be accepted.
  assign s_tready = ({1'b0, q_level} + {2'b00, res_valid}) <= 3'(OQ_DEPTH - 1);
  assign s_accept = s_tvalid && s_tready;

  mbcs_walk u_walk (
    .clk         (clk),
    .rst         (rst),
    .state_count (state_count),
    .siso_mode   (siso_mode),
    .accept      (s_accept),
    .item        (item),
    .res_valid   (res_valid),
    .res         (res)
  );

  assign m_pop = m_tvalid && m_tready;

  mbcs_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .pop       (m_pop),
    .not_empty (m_tvalid),
    .head      (q_head),
    .level     (q_level)
  );

  assign m_tdata = {{(M_TDATA_W - $bits(result_t)){1'b0}}, q_head};

  // A result never arrives at a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(res_valid && (q_level == 2'(OQ_DEPTH)) && !m_pop))
    else $error("result queue overflow");

  // The last byte of a sequence yields a result in the following cycle.
  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    (s_accept && (s_tuser == KIND_BYTE) && s_tlast) |=> res_valid)
    else $error("missing result for last byte");

  // Only a completed last byte produces a result.
  a_result_has_byte: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> $past(s_accept && (s_tuser == KIND_BYTE) && s_tlast))
    else $error("result without a last byte");

  // An errored result carries a zero count.
  a_error_zero_count: assert property (@(posedge clk) disable iff (rst)
    (res_valid && (res.error_code != ERR_NONE)) |-> (res.char_count == 8'd0))
    else $error("non-zero count with error");

endmodule

[rtl/mbcs_walk.sv]
// ----------------------------------------------------------------------------
// mbcs_walk
// State table memory and the two-stage walk: address formation on accept,
// entry evaluation when the registered read data returns.
// ----------------------------------------------------------------------------
module mbcs_walk (
  input  logic             clk,
  input  logic             rst,
  input  logic [7:0]       state_count,
  input  logic             siso_mode,
  input  logic             accept,
  input  mbcs_pkg::item_t  item,
  output logic             res_valid,
  output mbcs_pkg::result_t res
);
  import mbcs_pkg::*;

  entry_t mem [0:(1 << TBL_ADDR_W)-1];
  entry_t rdata;

  logic                  tbl_we;
  logic                  byte_acc;
  logic [TBL_ADDR_W-1:0] waddr;
  logic [TBL_ADDR_W-1:0] raddr;
  entry_t                wdata;

  // Held sequence state, valid when the evaluation stage is empty.
  logic [STATE_W-1:0] st_state;
  logic [7:0]         st_count;
  logic               st_mid;
  logic [2:0]         st_err;
  logic               st_first;

  // Evaluation stage: the byte's state before its lookup.
  logic               s1_valid;
  logic               s1_last;
  logic [7:0]         s1_len;
  logic [STATE_W-1:0] s1_state;
  logic [7:0]         s1_count;
  logic               s1_mid;
  logic [2:0]         s1_err;

  logic [STATE_W-1:0] post_state;
  logic [7:0]         post_count;
  logic               post_mid;
  logic [2:0]         post_err;
  logic [2:0]         fin_err;

  logic [STATE_W-1:0] eff_state;
  logic [7:0]         eff_count;
  logic               eff_mid;
  logic [2:0]         eff_err;
  logic               eff_first;

  logic [STATE_W-1:0] start_state;
  logic [7:0]         start_count;
  logic               start_mid;
  logic [2:0]         start_err;

  assign tbl_we   = accept && (item.kind == KIND_TABLE);
  assign byte_acc = accept && (item.kind == KIND_BYTE);
  assign waddr    = {item.row_index, item.byte_value};
  assign wdata    = '{fin: item.entry_is_final, nxt: item.entry_next_state,
                      act: item.entry_action};

  // Table writes and byte lookups never share a cycle, as one word is
  // accepted at most per cycle, so no bypass is needed.
  always_ff @(posedge clk) begin
    if (tbl_we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_comb begin
    post_state = s1_state;
    post_count = s1_count;
    post_mid   = s1_mid;
    post_err   = s1_err;
    if (s1_err == ERR_NONE) begin
      if (!rdata.fin) begin
        post_state = rdata.nxt;
        post_mid   = 1'b1;
      end else begin
        case (rdata.act) inside
          ACT_ILLEGAL:     post_err = ERR_ILLEGAL;
          ACT_CHANGE_ONLY: post_err = ERR_CHANGE_ONLY;
          ACT_UNASSIGNED:  post_err = ERR_UNASSIGNED;
          [ACT_VALID_LO:ACT_VALID_HI]: begin
            if (s1_count < 8'(MAX_SEQ_BYTES)) begin
              post_count = s1_count + 8'd1;
            end
            post_state = rdata.nxt;
            post_mid   = 1'b0;
          end
          default:         post_err = ERR_RESERVED;
        endcase
      end
    end
  end

  always_comb begin
    fin_err = post_err;
    if (post_err == ERR_NONE) begin
      if (post_mid) begin
        fin_err = ERR_TOO_SHORT;
      end else if (siso_mode && ({1'b0, s1_len} != {post_count, 1'b0})) begin
        fin_err = ERR_NOT_DBCS;
      end
    end
  end

  assign res_valid      = s1_valid && s1_last;
  assign res.error_code = fin_err;
  assign res.char_count = (fin_err == ERR_NONE) ? post_count : 8'd0;

  // The byte being accepted continues from the byte still under evaluation,
  // so the next read address is formed straight from the returning entry.
  always_comb begin
    if (s1_valid) begin
      eff_state = post_state;
      eff_count = post_count;
      eff_mid   = post_mid;
      eff_err   = post_err;
      eff_first = s1_last;
    end else begin
      eff_state = st_state;
      eff_count = st_count;
      eff_mid   = st_mid;
      eff_err   = st_err;
      eff_first = st_first;
    end
  end

  always_comb begin
    if (eff_first) begin
      start_state = (siso_mode && (item.seq_length == DBCS_SEQ_LEN)) ?
                    START_STATE_DBCS : START_STATE_SBCS;
      start_count = 8'd0;
      start_mid   = 1'b0;
      start_err   = (state_count == 8'd0) ? ERR_NO_STATES : ERR_NONE;
    end else begin
      start_state = eff_state;
      start_count = eff_count;
      start_mid   = eff_mid;
      start_err   = eff_err;
    end
  end

  assign raddr = {start_state, item.byte_value};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      st_state <= '0;
      st_count <= '0;
      st_mid   <= 1'b0;
      st_err   <= ERR_NONE;
      st_first <= 1'b1;
    end else begin
      s1_valid <= byte_acc;
      if (s1_valid) begin
        st_state <= post_state;
        st_count <= post_count;
        st_mid   <= post_mid;
        st_err   <= post_err;
        st_first <= s1_last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (byte_acc) begin
      s1_last  <= item.last;
      s1_len   <= item.seq_length;
      s1_state <= start_state;
      s1_count <= start_count;
      s1_mid   <= start_mid;
      s1_err   <= start_err;
    end
  end

endmodule

[rtl/mbcs_outq.sv]
// ----------------------------------------------------------------------------
// mbcs_outq
// Small result queue between the walk and the output stream.
// ----------------------------------------------------------------------------
module mbcs_outq (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  mbcs_pkg::result_t push_data,
  input  logic              pop,
  output logic              not_empty,
  output mbcs_pkg::result_t head,
  output logic [1:0]        level
);
  import mbcs_pkg::*;

  result_t    slots [0:OQ_DEPTH-1];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic       do_pop;

  assign not_empty = (level != 2'd0);
  assign do_pop    = pop && not_empty;
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == 2'(OQ_DEPTH - 1)) ? 2'd0 : wr_ptr + 2'd1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == 2'(OQ_DEPTH - 1)) ? 2'd0 : rd_ptr + 2'd1;
      end
      level <= level + 2'(push) - 2'(do_pop);
    end
  end

endmodule

[dv/mbcs_byte_sequence_char_counter_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbcs_byte_sequence_char_counter_unit_tb
// Self-checking bench for the charset state-table character counter. Table
// entries are loaded through the input stream before any byte reads them. A
// directed list covers every action code and error path. Random sequences
// then run under several register settings, with idle gaps on both streams
// and one long receiver hold-off. Every result is compared with a behavioural
// model of the table walk or, in the directed list, with a value given by hand.
// ----------------------------------------------------------------------------
module mbcs_byte_sequence_char_counter_unit_tb;
  import mbcs_pkg::*;

  localparam int CYCLE_LIMIT    = 1_000_000;
  localparam int RESULT_LATENCY = 2;
  localparam int HOLD_CYCLES    = 400;
  localparam int N_PHASES       = 6;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic                 s_tlast = 1'b0;
  logic                 s_tuser = 1'b0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [2:0]           paddr = '0;
  logic [31:0]          pwdata = '0;
  logic [31:0]          prdata;
  logic                 pready;

  mbcs_byte_sequence_char_counter_unit uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Shadow of the charset table and of the walk through it.
  entry_t             tbl_shadow [0:MAX_STATES*256-1];
  bit                 written [0:MAX_STATES*256-1];
  logic [7:0]         row_cols [0:MAX_STATES-1][$];
  logic [STATE_W-1:0] walk_state = '0;
  logic [7:0]         tally = '0;
  bit                 in_char = 1'b0;
  bit                 seq_start = 1'b1;
  logic [2:0]         seq_err = ERR_NONE;
  logic [7:0]         cfg_state_count = '0;
  logic               cfg_siso = 1'b0;

  result_t expected_tallies [$];
  result_t want_res;
  result_t got_res;

  int  cycle_count = 0;
  int  mismatches = 0;
  int  results_checked = 0;
  int  words_sent = 0;
  int  table_writes = 0;
  int  settings_used = 0;
  int  err_seen [0:7];
  bit  sender_calm = 1'b0;
  bit  hold_request = 1'b0;

  typedef struct {
    bit         setup;
    logic [7:0] sc;
    logic       siso;
    item_t      w;
    bit         typed;
    result_t    res;
  } plan_step_t;

  plan_step_t plan [$];

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_tallies.size());
      $display("FAIL");
      $finish;
    end
  end

  // Model of the block: applies one accepted word and returns any result.
  function automatic void advance_counter(input item_t w, output bit produced,
                                          output result_t res);
    entry_t e;
    produced = 1'b0;
    res = '0;
    if (w.kind == KIND_TABLE) begin
      if (!written[{w.row_index, w.byte_value}]) begin
        written[{w.row_index, w.byte_value}] = 1'b1;
        row_cols[w.row_index].push_back(w.byte_value);
      end
      e.fin = w.entry_is_final;
      e.nxt = w.entry_next_state;
      e.act = w.entry_action;
      tbl_shadow[{w.row_index, w.byte_value}] = e;
      return;
    end
    if (seq_start) begin
      walk_state = (cfg_siso && w.seq_length == DBCS_SEQ_LEN) ? START_STATE_DBCS
                                                              : START_STATE_SBCS;
      tally = '0;
      in_char = 1'b0;
      seq_err = (cfg_state_count == 8'd0) ? ERR_NO_STATES : ERR_NONE;
    end
    if (seq_err == ERR_NONE) begin
      e = tbl_shadow[{walk_state, w.byte_value}];
      if (!e.fin) begin
        walk_state = e.nxt;
        in_char = 1'b1;
      end else if (e.act == ACT_ILLEGAL) begin
        seq_err = ERR_ILLEGAL;
      end else if (e.act == ACT_CHANGE_ONLY) begin
        seq_err = ERR_CHANGE_ONLY;
      end else if (e.act == ACT_UNASSIGNED) begin
        seq_err = ERR_UNASSIGNED;
      end else if (e.act >= ACT_VALID_LO && e.act <= ACT_VALID_HI) begin
        if (tally < 8'(MAX_SEQ_BYTES)) tally = tally + 8'd1;
        walk_state = e.nxt;
        in_char = 1'b0;
      end else begin
        seq_err = ERR_RESERVED;
      end
    end
    seq_start = w.last;
    if (!w.last) return;
    if (seq_err == ERR_NONE) begin
      if (in_char) seq_err = ERR_TOO_SHORT;
      else if (cfg_siso && 9'(w.seq_length) != {tally, 1'b0}) seq_err = ERR_NOT_DBCS;
    end
    res.char_count = (seq_err == ERR_NONE) ? tally : 8'd0;
    res.error_code = seq_err;
    produced = 1'b1;
  endfunction

  // Offers one word, waits for it to be taken, then sometimes idles for a random gap.
  task automatic put_word(input item_t w, input bit typed, input result_t given);
    bit      produced;
    result_t res;
    int      gap;
    int      r;
    s_tvalid <= 1'b1;
    s_tuser  <= w.kind;
    s_tlast  <= w.last;
    s_tdata  <= {5'b0, w.entry_action, w.entry_next_state, w.entry_is_final,
                 w.row_index, w.seq_length, w.byte_value};
    do @(posedge clk); while (!s_tready);
    advance_counter(w, produced, res);
    if (produced) expected_tallies.push_back(typed ? given : res);
    words_sent++;
    if (w.kind == KIND_TABLE) table_writes++;
    r = $urandom_range(99);
    if (sender_calm || r < 55) gap = 0;
    else if (r < 88) gap = $urandom_range(3, 1);
    else if (r < 98) gap = $urandom_range(12, 4);
    else gap = $urandom_range(60, 20);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_entry(input logic [STATE_W-1:0] row, input logic [7:0] col,
                             input logic fin, input logic [STATE_W-1:0] nxt,
                             input logic [3:0] act);
    item_t w;
    w.kind             = KIND_TABLE;
    w.last             = 1'($urandom);
    w.byte_value       = col;
    w.seq_length       = 8'($urandom);
    w.row_index        = row;
    w.entry_is_final   = fin;
    w.entry_next_state = nxt;
    w.entry_action     = act;
    put_word(w, 1'b0, '0);
  endtask

  // Sends one sequence byte. If the walk is about to read an entry that has
  // not been loaded yet, that entry is written first.
  task automatic feed_byte(input logic [7:0] len, input bit last_byte);
    item_t              w;
    logic [STATE_W-1:0] row;
    bit                 reads;
    logic               fin;
    logic [STATE_W-1:0] nxt;
    logic [3:0]         act;
    if ($urandom_range(99) < 4)
      write_entry(7'($urandom), 8'($urandom), 1'($urandom), 7'($urandom), 4'($urandom));
    if (seq_start) begin
      row = (cfg_siso && len == DBCS_SEQ_LEN) ? START_STATE_DBCS : START_STATE_SBCS;
      reads = cfg_state_count != 8'd0;
    end else begin
      row = walk_state;
      reads = seq_err == ERR_NONE;
    end
    w.kind             = KIND_BYTE;
    w.last             = last_byte;
    w.seq_length       = len;
    w.row_index        = 7'($urandom);
    w.entry_is_final   = 1'($urandom);
    w.entry_next_state = 7'($urandom);
    w.entry_action     = 4'($urandom);
    if (reads && row_cols[row].size() != 0 && $urandom_range(99) < 75)
      w.byte_value = row_cols[row][$urandom_range(row_cols[row].size() - 1)];
    else
      w.byte_value = 8'($urandom);
    if (reads && !written[{row, w.byte_value}]) begin
      fin = $urandom_range(99) >= 20;
      nxt = ($urandom_range(99) < 80) ? 7'($urandom_range(7)) : 7'($urandom);
      act = ($urandom_range(99) < 85) ? 4'($urandom_range(ACT_VALID_HI, ACT_VALID_LO))
                                      : 4'($urandom);
      // Double-byte rows: lead bytes from the start state, trail bytes back to it.
      if (cfg_siso && row == START_STATE_DBCS) begin
        fin = $urandom_range(99) < 25;
        nxt = 7'($urandom_range(5, 2));
      end else if (cfg_siso && row >= 7'd2 && row <= 7'd5) begin
        fin = $urandom_range(99) < 90;
        nxt = START_STATE_DBCS;
      end
      write_entry(row, w.byte_value, fin, nxt, act);
    end
    put_word(w, 1'b0, '0);
  endtask

  task automatic run_sequence();
    int         n;
    int         r;
    logic [7:0] len;
    r = $urandom_range(99);
    if (cfg_siso && r < 50) n = 2;
    else if (r < 80) n = $urandom_range(6, 1);
    else if (r < 96) n = $urandom_range(20, 7);
    else n = $urandom_range(255, 21);
    len = 8'(n);
    if ($urandom_range(99) < 8) len = 8'($urandom_range(255, 1));
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 3) len = 8'($urandom_range(255, 1));
      feed_byte(len, i == n - 1);
    end
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    while (expected_tallies.size() != 0) @(posedge clk);
    repeat (RESULT_LATENCY + 2) @(posedge clk);
  endtask

  // Register write followed by a read-back of the same register.
  task automatic write_reg(input logic idx, input logic [31:0] value);
    logic [31:0] got;
    bit          same;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == REG_IDX_STATE_COUNT) cfg_state_count = value[7:0];
    else cfg_siso = value[0];
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    same = (idx == REG_IDX_STATE_COUNT) ? got[7:0] == value[7:0] : got[0] == value[0];
    if (!same) begin
      if (mismatches < 10)
        $display("register %0d read back %h, wrote %h", idx, got, value);
      mismatches++;
    end
  endtask

  task automatic set_config(input logic [7:0] sc, input logic siso);
    settle();
    write_reg(REG_IDX_STATE_COUNT, {24'b0, sc});
    write_reg(REG_IDX_SISO_MODE, {31'b0, siso});
    settings_used++;
  endtask

  function automatic void plan_setup(input logic [7:0] sc, input logic siso);
    plan_step_t s;
    s.setup = 1'b1;
    s.sc    = sc;
    s.siso  = siso;
    s.w     = '0;
    s.typed = 1'b0;
    s.res   = '0;
    plan.push_back(s);
  endfunction

  function automatic void plan_table(input logic [STATE_W-1:0] row, input logic [7:0] col,
                                     input logic fin, input logic [STATE_W-1:0] nxt,
                                     input logic [3:0] act);
    plan_step_t s;
    s.setup              = 1'b0;
    s.sc                 = '0;
    s.siso               = 1'b0;
    s.w                  = '0;
    s.w.kind             = KIND_TABLE;
    s.w.byte_value       = col;
    s.w.row_index        = row;
    s.w.entry_is_final   = fin;
    s.w.entry_next_state = nxt;
    s.w.entry_action     = act;
    s.typed              = 1'b0;
    s.res                = '0;
    plan.push_back(s);
  endfunction

  // A byte; when it closes a sequence, its result is given here by hand.
  function automatic void plan_byte(input logic [7:0] b, input logic [7:0] len,
                                    input bit last_byte, input logic [7:0] cnt,
                                    input logic [2:0] err);
    plan_step_t s;
    s.setup          = 1'b0;
    s.sc             = '0;
    s.siso           = 1'b0;
    s.w              = '0;
    s.w.kind         = KIND_BYTE;
    s.w.byte_value   = b;
    s.w.seq_length   = len;
    s.w.last         = last_byte;
    s.typed          = last_byte;
    s.res.char_count = cnt;
    s.res.error_code = err;
    plan.push_back(s);
  endfunction

  // Result checker.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_res = result_t'(m_tdata[10:0]);
      err_seen[got_res.error_code] <= err_seen[got_res.error_code] + 1;
      results_checked <= results_checked + 1;
      if (expected_tallies.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result: count %0d error %0d",
                   got_res.char_count, got_res.error_code);
        mismatches <= mismatches + 1;
      end else begin
        want_res = expected_tallies.pop_front();
        if (got_res.char_count !== want_res.char_count ||
            got_res.error_code !== want_res.error_code) begin
          if (mismatches < 10)
            $display("result %0d: count %0d error %0d, expected count %0d error %0d",
                     results_checked, got_res.char_count, got_res.error_code,
                     want_res.char_count, want_res.error_code);
          mismatches <= mismatches + 1;
        end
      end
    end
  end

  // Receiver: random ready pattern, plus one long hold-off on request.
  initial begin
    wait (!rst);
    @(posedge clk);
    forever begin
      int r;
      r = $urandom_range(99);
      if (hold_request) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end else if (r < 45) begin
        m_tready <= 1'b1;
        repeat ($urandom_range(40, 1)) @(posedge clk);
      end else if (r < 85) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(3, 1)) @(posedge clk);
      end else if (r < 97) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(12, 4)) @(posedge clk);
      end else begin
        m_tready <= 1'b0;
        repeat ($urandom_range(60, 20)) @(posedge clk);
      end
    end
  end

  initial begin
    logic [7:0] phase_sc [0:N_PHASES-1];
    logic       phase_siso [0:N_PHASES-1];
    int         phase_words [0:N_PHASES-1];
    int         phase_start;
    int         drain_cycles;
    item_t      w;

    phase_sc    = '{8'd1, 8'd255, 8'd128, 8'd0, 8'd37, 8'd128};
    phase_siso  = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
    phase_words = '{300, 450, 350, 60, 300, 350};
    for (int i = 0; i < 8; i++) err_seen[i] = 0;

    // Right after reset state_count is zero, so the first sequence reports it.
    plan_byte(8'h41, 8'd1, 1'b1, 8'd0, ERR_NO_STATES);
    plan_setup(8'd1, 1'b0);
    plan_table(7'd0, 8'h00, 1'b1, 7'd0, ACT_VALID_LO);
    plan_table(7'd0, 8'hFF, 1'b1, 7'd0, ACT_VALID_HI);
    plan_table(7'd0, 8'h81, 1'b0, 7'd127, 4'hF);
    plan_table(7'd127, 8'h40, 1'b1, 7'd0, 4'd5);
    plan_table(7'd0, 8'h01, 1'b1, 7'd0, ACT_ILLEGAL);
    plan_table(7'd0, 8'h02, 1'b1, 7'd0, ACT_CHANGE_ONLY);
    plan_table(7'd0, 8'h03, 1'b1, 7'd0, ACT_UNASSIGNED);
    plan_table(7'd0, 8'h04, 1'b1, 7'd0, 4'd9);
    plan_table(7'd0, 8'h05, 1'b1, 7'd0, 4'd15);
    plan_byte(8'h00, 8'd1, 1'b1, 8'd1, ERR_NONE);
    plan_byte(8'hFF, 8'd1, 1'b1, 8'd1, ERR_NONE);
    plan_byte(8'h81, 8'd2, 1'b0, 8'd0, ERR_NONE);
    plan_byte(8'h40, 8'd2, 1'b1, 8'd1, ERR_NONE);
    plan_byte(8'h81, 8'd1, 1'b1, 8'd0, ERR_TOO_SHORT);
    // Only the first error counts; later bytes of the sequence are ignored.
    plan_byte(8'h01, 8'd3, 1'b0, 8'd0, ERR_NONE);
    plan_byte(8'h02, 8'd3, 1'b0, 8'd0, ERR_NONE);
    plan_byte(8'h00, 8'd3, 1'b1, 8'd0, ERR_ILLEGAL);
    plan_byte(8'h02, 8'd1, 1'b1, 8'd0, ERR_CHANGE_ONLY);
    plan_byte(8'h03, 8'd1, 1'b1, 8'd0, ERR_UNASSIGNED);
    plan_byte(8'h04, 8'd1, 1'b1, 8'd0, ERR_RESERVED);
    plan_byte(8'h05, 8'd1, 1'b1, 8'd0, ERR_RESERVED);
    // Shift mode: a two-byte sequence starts in the double-byte state.
    plan_setup(8'd128, 1'b1);
    plan_table(7'd1, 8'h20, 1'b0, 7'd2, ACT_ILLEGAL);
    plan_table(7'd2, 8'h21, 1'b1, 7'd1, ACT_VALID_LO);
    plan_byte(8'h20, 8'd2, 1'b0, 8'd0, ERR_NONE);
    plan_byte(8'h21, 8'd2, 1'b1, 8'd1, ERR_NONE);
    plan_byte(8'h00, 8'd1, 1'b1, 8'd0, ERR_NOT_DBCS);

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].setup) set_config(plan[i].sc, plan[i].siso);
      else put_word(plan[i].w, plan[i].typed, plan[i].res);
    end

    for (int p = 0; p < N_PHASES; p++) begin
      set_config(phase_sc[p], phase_siso[p]);
      phase_start = words_sent;
      // Stall the receiver early on so that the result queue fills up.
      if (p == 0) hold_request = 1'b1;
      if (p == 1) begin
        write_entry(7'd0, 8'h55, 1'b1, 7'd0, 4'd6);
        w = '0;
        w.kind = KIND_BYTE;
        w.byte_value = 8'h55;
        w.seq_length = 8'd255;
        for (int i = 0; i < 300; i++) begin
          w.last = (i == 299);
          put_word(w, 1'b0, '0);
        end
      end
      while (words_sent - phase_start < phase_words[p]) begin
        sender_calm = $urandom_range(99) < 20;
        run_sequence();
      end
    end

    s_tvalid <= 1'b0;
    drain_cycles = 0;
    while (expected_tallies.size() != 0 && drain_cycles < 20000) begin
      @(posedge clk);
      drain_cycles++;
    end
    repeat (RESULT_LATENCY + 6) @(posedge clk);
    if (expected_tallies.size() != 0) begin
      $display("%0d expected results never arrived", expected_tallies.size());
      mismatches += expected_tallies.size();
    end

    $display("Sent %0d words (%0d table writes) under %0d register settings; %0d results checked.",
             words_sent, table_writes, settings_used, results_checked);
    $display("Results by error code 0..7: %0d %0d %0d %0d %0d %0d %0d %0d",
             err_seen[0], err_seen[1], err_seen[2], err_seen[3],
             err_seen[4], err_seen[5], err_seen[6], err_seen[7]);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
